// File: hw/rtl/hmq_pkg.sv
// ----------------------------------------------------------------------------
// hmq_pkg
// Shared types and constants of the hypervector mismatch query block.
// ----------------------------------------------------------------------------
package hmq_pkg;

	localparam int NUM_VECTORS_DEF = 16;
	localparam int MAX_WORDS_DEF   = 1024;
	localparam int WORD_BITS_DEF   = 64;

	localparam int ROW_W   = 4;
	localparam int IDX_W   = 10;
	localparam int VAL_W   = 64;
	localparam int SCORE_W = 11;
	localparam int VIU_W   = 5;
	localparam int WIU_W   = 11;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_ADDR_W-1:0] REG_VECTORS_IN_USE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WORDS_IN_USE   = 2'd1;

	localparam logic [VIU_W-1:0] VIU_RESET = 5'd16;
	localparam logic [WIU_W-1:0] WIU_RESET = 11'd1024;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	typedef struct packed {
		logic             func;
		logic [ROW_W-1:0] row;
		logic [IDX_W-1:0] word_index;
		logic [VAL_W-1:0] value;
	} hmq_in_t;

	typedef struct packed {
		logic [ROW_W-1:0]   class_row;
		logic [SCORE_W-1:0] score;
		logic               last;
	} hmq_out_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last_word;
	} hmq_ctl_t;

endpackage

// File: hw/rtl/hmq_ram.sv
// ----------------------------------------------------------------------------
// hmq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/hmq_class_store.sv
// ----------------------------------------------------------------------------
// hmq_class_store
// Class vector store: one RAM bank per row, all banks read at one word index.
// ----------------------------------------------------------------------------
module hmq_class_store #(
	parameter int NUM_VECTORS = hmq_pkg::NUM_VECTORS_DEF,
	parameter int MAX_WORDS   = hmq_pkg::MAX_WORDS_DEF,
	parameter int WORD_BITS   = hmq_pkg::WORD_BITS_DEF,
	parameter int AW          = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
	parameter int RW          = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [RW-1:0]                         wrow,
	input  logic [AW-1:0]                         waddr,
	input  logic [WORD_BITS-1:0]                  wdata,
	input  logic                                  re,
	input  logic [AW-1:0]                         raddr,
	output logic [NUM_VECTORS-1:0][WORD_BITS-1:0] rdata
);

	for (genvar r = 0; r < NUM_VECTORS; r++) begin : g_bank
		hmq_ram #(
			.WIDTH (WORD_BITS),
			.DEPTH (MAX_WORDS),
			.AW    (AW)
		) u_ram (
			.clk   (clk),
			.we    (we && (wrow == RW'(r))),
			.waddr (waddr),
			.wdata (wdata),
			.re    (re),
			.raddr (raddr),
			.rdata (rdata[r])
		);
	end

endmodule

// File: hw/rtl/hmq_scorer.sv
// ----------------------------------------------------------------------------
// hmq_scorer
// Per-row mismatch counters and the score readout onto the result channel.
// ----------------------------------------------------------------------------
module hmq_scorer #(
	parameter int NUM_VECTORS = hmq_pkg::NUM_VECTORS_DEF,
	parameter int WORD_BITS   = hmq_pkg::WORD_BITS_DEF,
	parameter int NV_W        = $clog2(NUM_VECTORS + 1),
	parameter int RW          = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hmq_pkg::hmq_ctl_t                     ctl_s1,
	input  logic [WORD_BITS-1:0]                  value_s1,
	input  logic [NUM_VECTORS-1:0][WORD_BITS-1:0] rdata,
	input  logic [NV_W-1:0]                       nv,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output hmq_pkg::hmq_out_t                     result_word,
	output logic                                  busy
);

	import hmq_pkg::*;

	logic [SCORE_W-1:0] scores_q [NUM_VECTORS];
	logic [SCORE_W-1:0] scores_d [NUM_VECTORS];
	logic               emit_q;
	logic [RW-1:0]      emit_row_q;
	logic               result_valid_q;
	hmq_out_t           result_word_q;
	logic               emit_last;
	logic               load_out;

	always_comb begin
		logic [SCORE_W-1:0] base;
		base = '0;
		for (int r = 0; r < NUM_VECTORS; r++) begin
			base = ctl_s1.first ? '0 : scores_q[r];
			if ((r < int'(nv)) && (rdata[r] != value_s1) && (base != SCORE_MAX)) begin
				scores_d[r] = base + SCORE_W'(1);
			end else begin
				scores_d[r] = base;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_VECTORS; r++) begin
				scores_q[r] <= '0;
			end
		end else if (ctl_s1.valid) begin
			for (int r = 0; r < NUM_VECTORS; r++) begin
				scores_q[r] <= scores_d[r];
			end
		end
	end

	assign emit_last = (int'(emit_row_q) == int'(nv) - 1);
	assign load_out  = emit_q && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q         <= 1'b0;
			emit_row_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (ctl_s1.valid && ctl_s1.last_word) begin
				emit_q     <= 1'b1;
				emit_row_q <= '0;
			end else if (load_out) begin
				if (emit_last) begin
					emit_q <= 1'b0;
				end else begin
					emit_row_q <= emit_row_q + RW'(1);
				end
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_word_q.class_row <= ROW_W'(emit_row_q);
			result_word_q.score     <= scores_q[emit_row_q];
			result_word_q.last      <= emit_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_word_q;
	assign busy         = emit_q;

endmodule

// File: hw/rtl/hypervector_mismatch_query.sv
// ----------------------------------------------------------------------------
// hypervector_mismatch_query
// Associative search of query hypervectors against stored class vectors.
//
// Item channel (item_valid/item_ready/item_word): a load word writes one
// word of one class row into its RAM bank; a query word reads that word
// index from every bank at once and, in the following cycle, bumps the
// mismatch count of each row in use whose word differs. Words are taken
// one per cycle while item_ready is high. Result channel (result_valid/
// result_ready/result_word): after the query word with the last index in
// use, one word per row in use follows, in row order, last set on the
// final one, through ctl_s1, the emit flag and the output register.
// item_ready drops once that query word is taken and stays low until the
// final result is in the output register, longer while the receiver stalls.
// Config channel (cfg_valid/cfg_ready/cfg_addr/cfg_data) is always ready.
// Reset sets rows in use to 16, words in use to 1024 and clears the scores;
// class RAM contents are not cleared and must be loaded before a query.
// ----------------------------------------------------------------------------
module hypervector_mismatch_query #(
	parameter int NUM_VECTORS = hmq_pkg::NUM_VECTORS_DEF,
	parameter int MAX_WORDS   = hmq_pkg::MAX_WORDS_DEF,
	parameter int WORD_BITS   = hmq_pkg::WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  hmq_pkg::hmq_in_t                   item_word,
	output logic                               result_valid,
	input  logic                               result_ready,
	output hmq_pkg::hmq_out_t                  result_word,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hmq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [hmq_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import hmq_pkg::*;

	localparam int AW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int RW   = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
	localparam int NV_W = $clog2(NUM_VECTORS + 1);
	localparam int NW_W = $clog2(MAX_WORDS + 1);

	logic [VIU_W-1:0]                      viu_q;
	logic [WIU_W-1:0]                      wiu_q;
	logic [NV_W-1:0]                       nv;
	logic [NW_W-1:0]                       nw;
	logic                                  accept;
	logic                                  is_load;
	logic                                  is_query;
	hmq_ctl_t                              ctl_s1;
	logic [WORD_BITS-1:0]                  value_s1;
	logic [NUM_VECTORS-1:0][WORD_BITS-1:0] rdata;
	logic                                  busy;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viu_q <= VIU_RESET;
			wiu_q <= WIU_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_VECTORS_IN_USE: viu_q <= cfg_data[VIU_W-1:0];
				REG_WORDS_IN_USE:   wiu_q <= cfg_data[WIU_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate to the legal ranges
	always_comb begin
		if (viu_q == '0) begin
			nv = NV_W'(1);
		end else if (int'(viu_q) > NUM_VECTORS) begin
			nv = NV_W'(NUM_VECTORS);
		end else begin
			nv = NV_W'(viu_q);
		end
		if (wiu_q == '0) begin
			nw = NW_W'(1);
		end else if (int'(wiu_q) > MAX_WORDS) begin
			nw = NW_W'(MAX_WORDS);
		end else begin
			nw = NW_W'(wiu_q);
		end
	end

	assign item_ready = !(ctl_s1.valid && ctl_s1.last_word) && !busy;
	assign accept     = item_valid && item_ready;
	assign is_load    = accept && (item_word.func == FUNC_LOAD)
		&& (int'(item_word.row) < NUM_VECTORS)
		&& (int'(item_word.word_index) < MAX_WORDS);
	assign is_query   = accept && (item_word.func == FUNC_QUERY)
		&& (int'(item_word.word_index) < int'(nw));

	hmq_class_store #(
		.NUM_VECTORS (NUM_VECTORS),
		.MAX_WORDS   (MAX_WORDS),
		.WORD_BITS   (WORD_BITS),
		.AW          (AW),
		.RW          (RW)
	) u_store (
		.clk   (clk),
		.we    (is_load),
		.wrow  (RW'(item_word.row)),
		.waddr (AW'(item_word.word_index)),
		.wdata (item_word.value[WORD_BITS-1:0]),
		.re    (is_query),
		.raddr (AW'(item_word.word_index)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid     <= is_query;
			ctl_s1.first     <= (item_word.word_index == '0);
			ctl_s1.last_word <= (int'(item_word.word_index) == int'(nw) - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			value_s1 <= item_word.value[WORD_BITS-1:0];
		end
	end

	hmq_scorer #(
		.NUM_VECTORS (NUM_VECTORS),
		.WORD_BITS   (WORD_BITS),
		.NV_W        (NV_W),
		.RW          (RW)
	) u_scorer (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.value_s1     (value_s1),
		.rdata        (rdata),
		.nv           (nv),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word),
		.busy         (busy)
	);

endmodule

// File: hw/rtl/hmq_checker.sv
// ----------------------------------------------------------------------------
// hmq_checker
// Port-level checks of the result readout, bound to the top level.
// ----------------------------------------------------------------------------
module hmq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input hmq_pkg::hmq_out_t result_word
);

	import hmq_pkg::*;

	// stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_word))
		else $error("result word changed while stalled");

	// no item taken while a readout is under way
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.last |-> !item_ready)
		else $error("item ready during score readout");

	// readout runs without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result_word.last |=> result_valid)
		else $error("gap in score readout");

	// a readout begins at row zero
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> result_word.class_row == '0)
		else $error("readout did not start at row zero");

	// rows follow in order
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result_word.last |=>
			result_word.class_row == $past(result_word.class_row) + ROW_W'(1))
		else $error("score rows out of order");

endmodule

bind hypervector_mismatch_query hmq_checker u_hmq_checker (.*);
